[sv/ts2ns_pkg.sv]
// ============================================================================
// ts2ns_pkg: shared types and constants for the timestamp-to-epoch converter
// Transaction structs, status codes, character codes, field positions,
// conversion constants and small lookup functions.
// ============================================================================
package ts2ns_pkg;

    localparam int MAX_FIELD_CHARS_DEF = 32;

    localparam int POS_W  = 6;
    localparam int ACC_W  = 64;
    localparam int K_W    = 30;
    localparam int YEAR_W = 14;
    localparam int FRAC_W = 30;
    localparam int FCNT_W = 4;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // character positions in YYYY-MM-DDTHH:MM:SS
    localparam logic [POS_W-1:0] POS_YEAR_DASH = 6'd4;
    localparam logic [POS_W-1:0] POS_MON_HI    = 6'd5;
    localparam logic [POS_W-1:0] POS_MON_LO    = 6'd6;
    localparam logic [POS_W-1:0] POS_DATE_DASH = 6'd7;
    localparam logic [POS_W-1:0] POS_DAY_HI    = 6'd8;
    localparam logic [POS_W-1:0] POS_DAY_LO    = 6'd9;
    localparam logic [POS_W-1:0] POS_T         = 6'd10;
    localparam logic [POS_W-1:0] POS_HR_HI     = 6'd11;
    localparam logic [POS_W-1:0] POS_HR_LO     = 6'd12;
    localparam logic [POS_W-1:0] POS_COLON_A   = 6'd13;
    localparam logic [POS_W-1:0] POS_MIN_HI    = 6'd14;
    localparam logic [POS_W-1:0] POS_MIN_LO    = 6'd15;
    localparam logic [POS_W-1:0] POS_COLON_B   = 6'd16;
    localparam logic [POS_W-1:0] POS_SEC_HI    = 6'd17;
    localparam logic [POS_W-1:0] POS_SEC_LO    = 6'd18;
    localparam logic [POS_W-1:0] POS_FRAC      = 6'd19;
    localparam logic [POS_W-1:0] POS_MAX       = 6'd63;

    localparam logic [FCNT_W-1:0] FRAC_DIGITS_MAX = 4'd9;

    // multiplier constants
    localparam logic [K_W-1:0] K_ERA  = 30'd146097;
    localparam logic [K_W-1:0] K_YEAR = 30'd365;
    localparam logic [K_W-1:0] K_DAY  = 30'd86400;
    localparam logic [K_W-1:0] K_HOUR = 30'd3600;
    localparam logic [K_W-1:0] K_MIN  = 30'd60;
    localparam logic [K_W-1:0] K_NS   = 30'd1000000000;

    localparam logic [20:0] EPOCH_DAYS = 21'd719468;

    localparam logic [ACC_W-1:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic signed [63:0] SECS_MAX = 64'sd9223372036;
    localparam logic signed [63:0] SECS_MIN = -64'sd9223372037;
    localparam logic signed [63:0] FRAC_MAX = 64'sd854775807;
    localparam logic signed [63:0] FRAC_MIN = 64'sd145224192;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] timestamp_ns;
        logic [1:0]         status;
        logic               iso_form;
    } out_item_t;

    typedef struct packed {
        logic                    start;
        logic                    load;
        logic signed [ACC_W-1:0] init;
        logic signed [ACC_W-1:0] x;
        logic [K_W-1:0]          k;
    } mac_cmd_t;

    typedef enum logic [3:0] {
        S_PARSE,
        S_EVAL,
        S_PREP,
        S_DAYS_ERA,
        S_DAYS_YOE,
        S_SECS_DAY,
        S_SECS_HR,
        S_SECS_MIN,
        S_FRAC,
        S_CHECK,
        S_NS,
        S_DONE
    } state_t;

    // days from March 1 to the first of the month (March-based year)
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd3:    r = 9'd0;
                4'd4:    r = 9'd31;
                4'd5:    r = 9'd61;
                4'd6:    r = 9'd92;
                4'd7:    r = 9'd122;
                4'd8:    r = 9'd153;
                4'd9:    r = 9'd184;
                4'd10:   r = 9'd214;
                4'd11:   r = 9'd245;
                4'd12:   r = 9'd275;
                4'd1:    r = 9'd306;
                4'd2:    r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // 10^(9 - digits): scales a fraction of n digits to nanoseconds
    function automatic logic [K_W-1:0] frac_scale(input logic [FCNT_W-1:0] n);
        logic [K_W-1:0] r;
        begin
            case (n)
                4'd0:    r = 30'd1000000000;
                4'd1:    r = 30'd100000000;
                4'd2:    r = 30'd10000000;
                4'd3:    r = 30'd1000000;
                4'd4:    r = 30'd100000;
                4'd5:    r = 30'd10000;
                4'd6:    r = 30'd1000;
                4'd7:    r = 30'd100;
                4'd8:    r = 30'd10;
                default: r = 30'd1;
            endcase
            return r;
        end
    endfunction

endpackage

[sv/ts2ns_mac.sv]
// ============================================================================
// ts2ns_mac: shift-add multiply-accumulate unit
// acc += x * k, one bit of the constant k per cycle; busy while k has bits.
// ============================================================================
module ts2ns_mac
    import ts2ns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_cmd_t                cmd,
    output logic                    busy,
    output logic signed [ACC_W-1:0] acc
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] x_reg, x_next;
    logic [K_W-1:0]   k_reg, k_next;

    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        k_next   = k_reg;
        if (cmd.start)
        begin
            if (cmd.load)
            begin
                acc_next = cmd.init;
            end
            x_next = cmd.x;
            k_next = cmd.k;
        end
        else if (k_reg != '0)
        begin
            if (k_reg[0])
            begin
                acc_next = acc_reg + x_reg;
            end
            x_next = {x_reg[ACC_W-2:0], 1'b0};
            k_next = {1'b0, k_reg[K_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
    end

    assign busy = (k_reg != '0);
    assign acc  = $signed(acc_reg);

endmodule

[sv/iso8601_timestamp_to_epoch_ns.sv]
// ============================================================================
// iso8601_timestamp_to_epoch_ns: timestamp text to Unix epoch nanoseconds
// Character-serial parser with a shared shift-add unit for the conversion.
// ============================================================================
// Usage:
//   char channel: one ASCII character per transaction; last marks the end of
//   the field. While a field is being parsed a character is taken every cycle.
//   result channel: one transaction per field, carrying timestamp_ns, status
//   and iso_form. timestamp_ns is zero unless status is ok.
// Conversion path:
//   Bare numbers and malformed or out-of-range date-times go from S_EVAL
//   to S_DONE and the output register. Valid ISO date-times use the shared
//   shift-add multiplier, which retires one bit of its constant per cycle
//   over seven products (era, year, day, hour, minute, fraction scale, 1e9).
//   char_stall is high from the cycle after the last character until the
//   result has moved to the output register.
// Reset: all parse state and the output valid flag clear; the block comes up
//   ready for the first character of a field.
// Receiver stall: the output register holds its transaction; the next field
//   may be parsed meanwhile, and its result waits in the result registers
//   until the output register frees up.
// ============================================================================
module iso8601_timestamp_to_epoch_ns
    import ts2ns_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  in_item_t  char_data,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    localparam logic [POS_W:0] LONG_POS = (POS_W + 1)'(MAX_FIELD_CHARS - 1);

    state_t state_reg, state_next;

    // parse state
    logic [POS_W-1:0]  cp_reg, cp_next;
    logic [ACC_W-1:0]  dig_reg, dig_next;
    logic              dig_ovf_reg, dig_ovf_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        day_reg, day_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        min_reg, min_next;
    logic [5:0]        sec_reg, sec_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic              notnum_reg, notnum_next;
    logic              malf_reg, malf_next;
    logic              range_reg, range_next;
    logic              infrac_reg, infrac_next;

    // conversion state
    logic signed [14:0] yp_reg, yp_next;
    logic signed [5:0]  era_reg, era_next;
    logic signed [63:0] secs_reg, secs_next;

    // pending result and output register
    out_item_t res_reg, res_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic     accept;
    logic     field_clear;
    mac_cmd_t mac_cmd;
    logic     mac_busy;
    logic signed [ACC_W-1:0] mac_acc;

    ts2ns_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    assign char_stall   = (state_reg != S_PARSE);
    assign accept       = char_valid && !char_stall;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // ------------------------------------------------------------------
    // Character parser
    // ------------------------------------------------------------------
    logic [7:0]        c;
    logic              isd;
    logic [3:0]        d;
    logic [ACC_W+3:0]  dig_prod;
    logic [7:0]        two_dig;
    logic [FRAC_W-1:0] frac_prod;

    always_comb
    begin
        c         = char_data.char_code;
        isd       = (c >= CH_ZERO) && (c <= CH_NINE);
        d         = 4'(c - CH_ZERO);
        dig_prod  = ({4'b0, dig_reg} << 3) + ({4'b0, dig_reg} << 1) + (ACC_W + 4)'(d);
        two_dig   = 8'(dig_reg[3:0]) * 8'd10 + 8'(d);
        frac_prod = (frac_reg << 3) + (frac_reg << 1) + FRAC_W'(d);

        cp_next      = cp_reg;
        dig_next     = dig_reg;
        dig_ovf_next = dig_ovf_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        frac_next    = frac_reg;
        fcnt_next    = fcnt_reg;
        notnum_next  = notnum_reg;
        malf_next    = malf_reg;
        range_next   = range_reg;
        infrac_next  = infrac_reg;

        if (field_clear)
        begin
            cp_next      = '0;
            dig_next     = '0;
            dig_ovf_next = 1'b0;
            year_next    = '0;
            month_next   = '0;
            day_next     = '0;
            hour_next    = '0;
            min_next     = '0;
            sec_next     = '0;
            frac_next    = '0;
            fcnt_next    = '0;
            notnum_next  = 1'b0;
            malf_next    = 1'b0;
            range_next   = 1'b0;
            infrac_next  = 1'b0;
        end
        else if (accept)
        begin
            cp_next = (cp_reg == POS_MAX) ? POS_MAX : cp_reg + 1'b1;
            if (!notnum_reg && isd)
            begin
                // bare number: too many digits is malformed, too large overflows
                if ({1'b0, cp_reg} >= LONG_POS)
                begin
                    malf_next = 1'b1;
                end
                if (!dig_ovf_reg)
                begin
                    if (dig_prod > {4'b0, ACC_MAX})
                    begin
                        dig_ovf_next = 1'b1;
                    end
                    else
                    begin
                        dig_next = dig_prod[ACC_W-1:0];
                    end
                end
            end
            else if (!notnum_reg)
            begin
                // first non-digit switches to date-time form
                notnum_next = 1'b1;
                if (cp_reg == POS_YEAR_DASH && c == CH_DASH)
                begin
                    year_next = dig_reg[YEAR_W-1:0];
                    dig_next  = '0;
                end
                else
                begin
                    malf_next = 1'b1;
                end
            end
            else if (cp_reg >= POS_FRAC)
            begin
                if (!infrac_reg)
                begin
                    if (cp_reg == POS_FRAC && c == CH_DOT)
                    begin
                        infrac_next = 1'b1;
                    end
                    else if (!(cp_reg == POS_FRAC && c == CH_Z && char_data.last))
                    begin
                        malf_next = 1'b1;
                    end
                end
                else if (isd && fcnt_reg < FRAC_DIGITS_MAX)
                begin
                    frac_next = frac_prod;
                    fcnt_next = fcnt_reg + 1'b1;
                end
                else if (!(c == CH_Z && char_data.last && fcnt_reg != '0))
                begin
                    malf_next = 1'b1;
                end
            end
            else
            begin
                case (cp_reg)
                    POS_DATE_DASH:
                    begin
                        if (c != CH_DASH) malf_next = 1'b1;
                    end
                    POS_T:
                    begin
                        if (c != CH_T) malf_next = 1'b1;
                    end
                    POS_COLON_A, POS_COLON_B:
                    begin
                        if (c != CH_COLON) malf_next = 1'b1;
                    end
                    POS_MON_HI, POS_DAY_HI, POS_HR_HI, POS_MIN_HI, POS_SEC_HI:
                    begin
                        if (isd) dig_next = ACC_W'(d);
                        else     malf_next = 1'b1;
                    end
                    POS_MON_LO:
                    begin
                        if (!isd) malf_next = 1'b1;
                        else if (two_dig >= 8'd1 && two_dig <= 8'd12) month_next = two_dig[3:0];
                        else range_next = 1'b1;
                    end
                    POS_DAY_LO:
                    begin
                        if (!isd) malf_next = 1'b1;
                        else if (two_dig >= 8'd1 && two_dig <= 8'd31) day_next = two_dig[4:0];
                        else range_next = 1'b1;
                    end
                    POS_HR_LO:
                    begin
                        if (!isd) malf_next = 1'b1;
                        else if (two_dig <= 8'd23) hour_next = two_dig[4:0];
                        else range_next = 1'b1;
                    end
                    POS_MIN_LO:
                    begin
                        if (!isd) malf_next = 1'b1;
                        else if (two_dig <= 8'd59) min_next = two_dig[5:0];
                        else range_next = 1'b1;
                    end
                    POS_SEC_LO:
                    begin
                        if (!isd) malf_next = 1'b1;
                        else if (two_dig <= 8'd60) sec_next = two_dig[5:0];
                        else range_next = 1'b1;
                    end
                    default:
                    begin
                        malf_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: status decision, then the conversion on the shared unit.
    //   days = era*146097 + yoe*365 + yoe/4 - yoe/100 + doy - 719468
    //   secs = days*86400 + hour*3600 + min*60 + sec
    //   ns   = secs*1e9 + frac*10^(9-digits)
    // ------------------------------------------------------------------
    logic               malf_f;
    logic signed [14:0] yp;
    logic [15:0]        ymul;
    logic [15:0]        yoe_w;
    logic [8:0]         yoe;
    logic [1:0]         cent;
    logic [8:0]         doy;
    logic [20:0]        base;
    logic               ns_ovf;

    always_comb
    begin
        malf_f = malf_reg || (cp_reg <= POS_SEC_LO) || (infrac_reg && fcnt_reg == '0);
        yp     = $signed({1'b0, year_reg}) - ((month_reg <= 4'd2) ? 15'sd1 : 15'sd0);
        // floor(yp/400) = floor(floor(yp/16)/25); /25 by reciprocal 41/1024
        ymul   = 16'(yp[13:4]) * 16'd41;

        yoe_w  = 16'(yp_reg) - 16'($signed({{10{era_reg[5]}}, era_reg}) * 16'sd400);
        yoe    = yoe_w[8:0];
        cent   = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
        doy    = days_before_month(month_reg) + 9'(day_reg) - 9'd1;
        base   = 21'(yoe[8:2]) - 21'(cent) + 21'(doy) - EPOCH_DAYS;

        ns_ovf = (secs_reg > SECS_MAX) || (secs_reg < SECS_MIN) ||
                 (secs_reg == SECS_MAX && mac_acc > FRAC_MAX) ||
                 (secs_reg == SECS_MIN && mac_acc < FRAC_MIN);
    end

    always_comb
    begin
        state_next     = state_reg;
        yp_next        = yp_reg;
        era_next       = era_reg;
        secs_next      = secs_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        field_clear    = 1'b0;
        mac_cmd        = '0;

        case (state_reg)
            S_PARSE:
            begin
                if (accept && char_data.last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_next.iso_form     = notnum_reg;
                res_next.timestamp_ns = '0;
                state_next            = S_DONE;
                if (notnum_reg)
                begin
                    if (malf_f)
                    begin
                        res_next.status = STATUS_MALFORMED;
                    end
                    else if (range_reg)
                    begin
                        res_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        yp_next    = yp;
                        era_next   = yp[14] ? -6'sd1 : $signed({1'b0, ymul[14:10]});
                        state_next = S_PREP;
                    end
                end
                else if (malf_reg)
                begin
                    res_next.status = STATUS_MALFORMED;
                end
                else if (dig_ovf_reg)
                begin
                    res_next.status = STATUS_OVERFLOW;
                end
                else
                begin
                    res_next.status       = STATUS_OK;
                    res_next.timestamp_ns = $signed(dig_reg);
                end
            end
            S_PREP:
            begin
                mac_cmd.start = 1'b1;
                mac_cmd.load  = 1'b1;
                mac_cmd.init  = $signed({{43{base[20]}}, base});
                mac_cmd.x     = $signed({{58{era_reg[5]}}, era_reg});
                mac_cmd.k     = K_ERA;
                state_next    = S_DAYS_ERA;
            end
            S_DAYS_ERA:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.x     = $signed(64'(yoe));
                    mac_cmd.k     = K_YEAR;
                    state_next    = S_DAYS_YOE;
                end
            end
            S_DAYS_YOE:
            begin
                // acc holds the day count
                if (!mac_busy)
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.load  = 1'b1;
                    mac_cmd.init  = $signed(64'(sec_reg));
                    mac_cmd.x     = mac_acc;
                    mac_cmd.k     = K_DAY;
                    state_next    = S_SECS_DAY;
                end
            end
            S_SECS_DAY:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.x     = $signed(64'(hour_reg));
                    mac_cmd.k     = K_HOUR;
                    state_next    = S_SECS_HR;
                end
            end
            S_SECS_HR:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.x     = $signed(64'(min_reg));
                    mac_cmd.k     = K_MIN;
                    state_next    = S_SECS_MIN;
                end
            end
            S_SECS_MIN:
            begin
                // acc holds seconds; park them and scale the fraction
                if (!mac_busy)
                begin
                    secs_next     = mac_acc;
                    mac_cmd.start = 1'b1;
                    mac_cmd.load  = 1'b1;
                    mac_cmd.init  = '0;
                    mac_cmd.x     = $signed(64'(frac_reg));
                    mac_cmd.k     = frac_scale(fcnt_reg);
                    state_next    = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (!mac_busy)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (ns_ovf)
                begin
                    res_next.status       = STATUS_OVERFLOW;
                    res_next.timestamp_ns = '0;
                    state_next            = S_DONE;
                end
                else
                begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.load  = 1'b1;
                    mac_cmd.init  = mac_acc;
                    mac_cmd.x     = secs_reg;
                    mac_cmd.k     = K_NS;
                    state_next    = S_NS;
                end
            end
            S_NS:
            begin
                if (!mac_busy)
                begin
                    res_next.status       = STATUS_OK;
                    res_next.timestamp_ns = mac_acc;
                    state_next            = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand off once the output register is free or draining
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    field_clear    = 1'b1;
                    state_next     = S_PARSE;
                end
            end
            default:
            begin
                state_next = S_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_PARSE;
            out_valid_reg <= 1'b0;
            cp_reg        <= '0;
            dig_reg       <= '0;
            dig_ovf_reg   <= 1'b0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            frac_reg      <= '0;
            fcnt_reg      <= '0;
            notnum_reg    <= 1'b0;
            malf_reg      <= 1'b0;
            range_reg     <= 1'b0;
            infrac_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cp_reg        <= cp_next;
            dig_reg       <= dig_next;
            dig_ovf_reg   <= dig_ovf_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            min_reg       <= min_next;
            sec_reg       <= sec_next;
            frac_reg      <= frac_next;
            fcnt_reg      <= fcnt_next;
            notnum_reg    <= notnum_next;
            malf_reg      <= malf_next;
            range_reg     <= range_next;
            infrac_reg    <= infrac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yp_reg   <= yp_next;
        era_reg  <= era_next;
        secs_reg <= secs_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

[sv/ts2ns_checker.sv]
// ============================================================================
// ts2ns_checker: port-level assertions for the timestamp converter
// Watches both channels of the top level; attached by bind.
// ============================================================================
module ts2ns_checker
    import ts2ns_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      char_valid,
    input logic      char_stall,
    input in_item_t  char_data,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // rejected fields carry a zero timestamp
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != STATUS_OK |-> result_data.timestamp_ns == '0)
        else $error("nonzero timestamp with error status");

    // a bare number never reports range errors nor goes negative
    a_bare_number: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.iso_form |->
            result_data.status != STATUS_RANGE && !result_data.timestamp_ns[63])
        else $error("bad bare-number result");

    // the sequencer closes the input after a field ends
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && char_data.last |=> char_stall)
        else $error("input open right after last character");

endmodule

bind iso8601_timestamp_to_epoch_ns ts2ns_checker u_ts2ns_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

[tb/epoch_result_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// epoch_result_checker: predicts and checks timestamp conversions
// Watches the char and result channels, parses each accepted character with
// its own copy of the parse state, queues one conversion per field and
// compares every accepted result against the oldest queued conversion.
// ============================================================================
module epoch_result_checker
    import ts2ns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    input  logic      char_stall,
    input  in_item_t  char_data,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result_data,
    output int        error_count,
    output int        fields_in_flight
);

    // parse flags
    localparam logic [4:0] FL_NOT_NUMERIC = 5'b00001;
    localparam logic [4:0] FL_MALFORMED   = 5'b00010;
    localparam logic [4:0] FL_RANGE       = 5'b00100;
    localparam logic [4:0] FL_IN_FRAC     = 5'b01000;

    localparam int REPORT_LIMIT = 10;

    logic [POS_W-1:0]  char_pos;
    logic [ACC_W-1:0]  num_acc;
    logic              num_ovf;
    logic [YEAR_W-1:0] year_val;
    logic [25:0]       date_time;   // mon[3:0] day[8:4] hr[13:9] min[19:14] sec[25:20]
    logic [FRAC_W-1:0] frac_val;
    logic [FCNT_W-1:0] frac_cnt;
    logic [4:0]        flags;
    out_item_t         conversions[$];
    int                errors;

    function automatic void clear_field();
        char_pos  = '0;
        num_acc   = '0;
        num_ovf   = 1'b0;
        year_val  = '0;
        date_time = '0;
        frac_val  = '0;
        frac_cnt  = '0;
        flags     = '0;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $time, msg);
    endfunction

    // out-of-range values are stored as zero
    function automatic void set_field(input int shift, input int bits, input int v,
                                      input int lo, input int hi);
        if (v < lo || v > hi) begin
            flags |= FL_RANGE;
            v = 0;
        end
        date_time |= 26'((v & ((1 << bits) - 1)) << shift);
    endfunction

    function automatic void scan_iso_char(input logic [POS_W-1:0] p, input logic [7:0] c,
                                          input logic l);
        logic is_digit;
        int   d;
        int   v;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = int'(c) - int'(CH_ZERO);
        if (p >= POS_FRAC) begin
            if ((flags & FL_IN_FRAC) == 0) begin
                if (p == POS_FRAC && c == CH_DOT)
                    flags |= FL_IN_FRAC;
                else if (!(p == POS_FRAC && c == CH_Z && l))
                    flags |= FL_MALFORMED;
            end
            else if (is_digit && frac_cnt < FRAC_DIGITS_MAX) begin
                frac_val = frac_val * 10 + FRAC_W'(d);
                frac_cnt++;
            end
            else if (!(c == CH_Z && l && frac_cnt >= 1)) begin
                flags |= FL_MALFORMED;
            end
        end
        else begin
            case (p)
                POS_DATE_DASH:
                    if (c != CH_DASH) flags |= FL_MALFORMED;
                POS_T:
                    if (c != CH_T) flags |= FL_MALFORMED;
                POS_COLON_A, POS_COLON_B:
                    if (c != CH_COLON) flags |= FL_MALFORMED;
                POS_MON_HI, POS_DAY_HI, POS_HR_HI, POS_MIN_HI, POS_SEC_HI:
                    if (is_digit) num_acc = ACC_W'(d);
                    else flags |= FL_MALFORMED;
                POS_MON_LO, POS_DAY_LO, POS_HR_LO, POS_MIN_LO, POS_SEC_LO:
                begin
                    if (!is_digit) begin
                        flags |= FL_MALFORMED;
                    end
                    else begin
                        v = int'(num_acc[3:0]) * 10 + d;
                        case (p)
                            POS_MON_LO: set_field(0, 4, v, 1, 12);
                            POS_DAY_LO: set_field(4, 5, v, 1, 31);
                            POS_HR_LO:  set_field(9, 5, v, 0, 23);
                            POS_MIN_LO: set_field(14, 6, v, 0, 59);
                            default:    set_field(20, 6, v, 0, 60);
                        endcase
                    end
                end
                default:
                    flags |= FL_MALFORMED;
            endcase
        end
    endfunction

    // proleptic Gregorian day count, March-based years
    function automatic longint days_since_epoch(input longint y, input int m, input int d);
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic void close_iso(input logic [POS_W-1:0] p,
                                      output logic signed [63:0] ts, output logic [1:0] st);
        longint secs;
        longint frac;
        longint hh;
        longint mm;
        longint ss;
        ts = '0;
        st = STATUS_OK;
        if (p < POS_SEC_LO || ((flags & FL_IN_FRAC) != 0 && frac_cnt == 0))
            flags |= FL_MALFORMED;
        if ((flags & FL_MALFORMED) != 0) begin
            st = STATUS_MALFORMED;
        end
        else if ((flags & FL_RANGE) != 0) begin
            st = STATUS_RANGE;
        end
        else begin
            frac = frac_val;
            hh   = date_time[13:9];
            mm   = date_time[19:14];
            ss   = date_time[25:20];
            for (int k = frac_cnt; k < 9; k++) frac = frac * 10;
            secs = days_since_epoch(year_val, date_time[3:0], date_time[8:4]) * 86400
                 + hh * 3600 + mm * 60 + ss;
            if (secs > SECS_MAX || secs < SECS_MIN ||
                (secs == SECS_MAX && frac > FRAC_MAX) ||
                (secs == SECS_MIN && frac < FRAC_MIN))
                st = STATUS_OVERFLOW;
            else
                ts = secs * 1000000000 + frac;
        end
    endfunction

    function automatic void decode_char(input in_item_t item);
        logic [7:0]         c;
        logic [POS_W-1:0]   p;
        logic               is_digit;
        logic [ACC_W-1:0]   d;
        logic signed [63:0] ts;
        logic [1:0]         st;
        out_item_t          conv;
        c = item.char_code;
        p = char_pos;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if ((flags & FL_NOT_NUMERIC) == 0 && is_digit) begin
            d = c - CH_ZERO;
            if (p >= MAX_FIELD_CHARS_DEF - 1)
                flags |= FL_MALFORMED;
            if (!num_ovf) begin
                if (num_acc > (ACC_MAX - d) / 10)
                    num_ovf = 1'b1;
                else
                    num_acc = num_acc * 10 + d;
            end
        end
        else if ((flags & FL_NOT_NUMERIC) == 0) begin
            flags |= FL_NOT_NUMERIC;
            if (p == POS_YEAR_DASH && c == CH_DASH) begin
                year_val = num_acc[YEAR_W-1:0];
                num_acc  = '0;
            end
            else begin
                flags |= FL_MALFORMED;
            end
        end
        else begin
            scan_iso_char(p, c, item.last);
        end
        char_pos = (p < POS_MAX) ? p + 1'b1 : POS_MAX;

        if (item.last) begin
            ts = '0;
            st = STATUS_OK;
            if ((flags & FL_NOT_NUMERIC) != 0)
                close_iso(p, ts, st);
            else if ((flags & FL_MALFORMED) != 0)
                st = STATUS_MALFORMED;
            else if (num_ovf)
                st = STATUS_OVERFLOW;
            else
                ts = num_acc;
            if (st != STATUS_OK) ts = '0;
            conv.timestamp_ns = ts;
            conv.status       = st;
            conv.iso_form     = (flags & FL_NOT_NUMERIC) != 0;
            conversions.push_back(conv);
            clear_field();
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : check_edge
        out_item_t want;
        if (!rst_n) begin
            clear_field();
            conversions.delete();
            errors = 0;
            error_count      <= 0;
            fields_in_flight <= 0;
        end
        else begin
            if (result_valid && !result_stall) begin
                if (conversions.size() == 0) begin
                    note_error($sformatf("unexpected result ts %0d status %0d iso %0d",
                        result_data.timestamp_ns, result_data.status, result_data.iso_form));
                end
                else begin
                    want = conversions.pop_front();
                    if (result_data.timestamp_ns !== want.timestamp_ns ||
                        result_data.status !== want.status ||
                        result_data.iso_form !== want.iso_form)
                        note_error($sformatf(
                            "expected ts %0d status %0d iso %0d, got ts %0d status %0d iso %0d",
                            want.timestamp_ns, want.status, want.iso_form,
                            result_data.timestamp_ns, result_data.status,
                            result_data.iso_form));
                end
            end
            if (char_valid && !char_stall)
                decode_char(char_data);
            error_count      <= errors;
            fields_in_flight <= conversions.size();
        end
    end

endmodule

[tb/iso8601_timestamp_to_epoch_ns_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// iso8601_timestamp_to_epoch_ns_test: testbench top for the epoch converter
// Sends timestamp fields one character per transaction: a directed set of
// edge cases, then random date-times, broken date-times, bare numbers and
// noise under four idle/stall phases. Checking lives in epoch_result_checker.
// ============================================================================
module iso8601_timestamp_to_epoch_ns_test;
    import ts2ns_pkg::*;

    localparam int RANDOM_CHARS = 1500;  // characters in the random part
    // longest quiet stretch is one ISO conversion plus stalls
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 200;   // past the slowest conversion

    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } phase_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       char_valid   = 1'b0;
    logic       char_stall;
    in_item_t   char_data    = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    out_item_t  result_data;

    int         error_count;
    int         fields_in_flight;
    int         send_idle_pct  = 0;   // chance per cycle the sender holds off
    int         recv_stall_pct = 0;   // chance per cycle the receiver stalls
    int         chars_sent     = 0;
    int         quiet_cycles   = 0;
    logic [7:0] field_q[$];           // characters of the field being built

    iso8601_timestamp_to_epoch_ns dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    epoch_result_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_valid       (char_valid),
        .char_stall       (char_stall),
        .char_data        (char_data),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result_data      (result_data),
        .error_count      (error_count),
        .fields_in_flight (fields_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall is drawn fresh every cycle; it never looks at valid.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: any cycle with a transaction on either channel resets the
    // count. A hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One character transaction. Idle gaps are drawn before the character so
    // valid stays up across back-to-back characters when no gap is drawn.
    // Stall is sampled right after the edge, i.e. the value the edge saw.
    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{char_code: c, last: l};
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
    endtask

    task automatic send_field();
        for (int i = 0; i < field_q.size(); i++)
            send_char(field_q[i], i == field_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        field_q.delete();
        for (int i = 0; i < s.len(); i++)
            field_q.push_back(s[i]);
        send_field();
    endtask

    // Sender holds off until every queued conversion has come back.
    task automatic drain_results();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (fields_in_flight != 0);
    endtask

    // zero-padded decimal, w digits
    function automatic void push_digits(input longint unsigned v, input int w);
        logic [7:0] digits[$];
        for (int k = 0; k < w; k++)
        begin
            digits.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end
        field_q = {field_q, digits};
    endfunction

    function automatic void push_random_digits(input int n);
        repeat (n) field_q.push_back(8'($urandom_range(CH_NINE, CH_ZERO)));
    endfunction

    // Mostly well-formed date-time with random content. A slice sits on the
    // exact first/last representable second so the ninth fraction digit
    // decides overflow; years near the ends of the range are favored.
    function automatic void build_iso();
        int              yr;
        int              mo;
        int              dy;
        int              hr;
        int              mi;
        int              se;
        int              pick;
        longint unsigned frac_head;
        pick = $urandom_range(19);
        frac_head = 0;
        if (pick == 0)
        begin
            yr = 2262; mo = 4; dy = 11; hr = 23; mi = 47; se = 16;
            frac_head = 85477580;
        end
        else if (pick == 1)
        begin
            yr = 1677; mo = 9; dy = 21; hr = 0; mi = 12; se = 43;
            frac_head = 14522419;
        end
        else
        begin
            case ($urandom_range(7))
                0:       yr = $urandom_range(9999);
                1:       yr = $urandom_range(1) ? $urandom_range(1678, 1676)
                                                : $urandom_range(2263, 2261);
                default: yr = $urandom_range(2261, 1678);
            endcase
            // now and then a two-digit field anywhere in 00..99
            mo = ($urandom_range(15) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
            dy = ($urandom_range(15) == 0) ? $urandom_range(99) : $urandom_range(31, 1);
            hr = ($urandom_range(15) == 0) ? $urandom_range(99) : $urandom_range(23);
            mi = ($urandom_range(15) == 0) ? $urandom_range(99) : $urandom_range(59);
            se = ($urandom_range(15) == 0) ? $urandom_range(99) : $urandom_range(60);
        end
        field_q.delete();
        push_digits(yr, 4);
        field_q.push_back(CH_DASH);
        push_digits(mo, 2);
        field_q.push_back(CH_DASH);
        push_digits(dy, 2);
        field_q.push_back(CH_T);
        push_digits(hr, 2);
        field_q.push_back(CH_COLON);
        push_digits(mi, 2);
        field_q.push_back(CH_COLON);
        push_digits(se, 2);
        if (pick < 2)
        begin
            field_q.push_back(CH_DOT);
            push_digits(frac_head, 8);
            push_random_digits(1);
        end
        else if ($urandom_range(2) != 0)
        begin
            // rarely an empty or a ten-digit fraction
            field_q.push_back(CH_DOT);
            push_random_digits(($urandom_range(9) == 0) ? $urandom_range(1) * 10
                                                        : $urandom_range(9, 1));
        end
        if ($urandom_range(1))
            field_q.push_back(CH_Z);
    endfunction

    initial
    begin
        phase_t phase;
        phase_t next_phase;
        int     kind;
        int     pos;

        phase = PH_STEADY;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: bare numbers ----
        send_text("0");
        send_text("9223372036854775807");      // largest signed 64-bit value
        send_text("9223372036854775808");      // one past it: overflow
        field_q.delete();
        push_digits(123, 31);                  // longest allowed, leading zeros
        send_field();
        field_q.delete();
        push_digits(1, 32);                    // one digit too many
        send_field();
        field_q.delete();
        repeat (32) field_q.push_back(CH_NINE);  // too long and too large: shape wins
        send_field();

        // ---- directed: date-times ----
        send_text("1970-01-01T00:00:00");
        send_text("1970-01-01T00:00:00Z");
        send_text("2262-04-11T23:47:16.854775807");
        send_text("2262-04-11T23:47:16.854775808");
        send_text("1677-09-21T00:12:43.145224192");
        send_text("1677-09-21T00:12:43.145224191");
        send_text("2000-02-29T12:30:60.5Z");   // leap second allowed
        send_text("1999-12-31T23:59:59.123456789Z");
        send_text("2024-13-01T00:00:00");      // month out of range
        send_text("2024-00-32T24:60:61");      // every field but the year out of range
        send_text("2024-13-01X00:00:00");      // bad shape beats bad range
        send_text("2024-01-01T00:00:00Z.");    // Z before the end
        send_text("2024-01-01T00:00:00.1234567890");
        send_text("2024-01-01T00:00:00.");     // empty fraction
        send_text(" 2024-01-01T00:00:00");     // leading whitespace
        send_text("2024-01-01");               // too short
        send_text("0000-01-01T00:00:00");      // far below the range
        send_text("9999-12-31T23:59:59.999999999Z");
        field_q = '{8'hFF, 8'h00};
        send_field();

        // ---- random part, split into four idle/stall phases ----
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            next_phase = phase_t'(chars_sent * 4 / RANDOM_CHARS);
            if (next_phase != phase)
            begin
                phase = next_phase;
                drain_results();
                case (phase)
                    PH_SENDER_IDLE:
                    begin
                        send_idle_pct  = 51;
                        recv_stall_pct = 0;
                    end
                    PH_RECEIVER_STALL:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 51;
                    end
                    PH_BOTH_IDLE:
                    begin
                        send_idle_pct  = 30;
                        recv_stall_pct = 30;
                    end
                    default:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                endcase
            end

            kind = $urandom_range(99);
            if (kind < 65)
            begin
                build_iso();
                if (kind >= 45)
                begin
                    // broken date-time: one character hit, dropped, added,
                    // or the tail cut off
                    pos = $urandom_range(field_q.size() - 1);
                    case ($urandom_range(3))
                        0: field_q[pos] = 8'($urandom_range(255));
                        1: field_q.delete(pos);
                        2: field_q.insert(pos, 8'($urandom_range(255)));
                        default:
                            while (field_q.size() > pos + 1)
                                void'(field_q.pop_back());
                    endcase
                end
            end
            else if (kind < 88)
            begin
                // bare number; some right at the 64-bit limit, some too long
                field_q.delete();
                if ($urandom_range(4) == 0)
                begin
                    push_digits(64'd922337203685477580, 18);
                    push_random_digits(1);
                end
                else
                begin
                    push_random_digits(($urandom_range(3) == 0) ? $urandom_range(35, 20)
                                                                : $urandom_range(19, 1));
                end
            end
            else
            begin
                // noise: optional digit run, then arbitrary bytes
                field_q.delete();
                if ($urandom_range(1))
                    push_random_digits($urandom_range(5));
                repeat ($urandom_range(8, 1)) field_q.push_back(8'($urandom_range(255)));
            end

            if ($urandom_range(39) == 0)
                drain_results();
            send_field();
        end

        // ---- wind down: wait for the last conversions, then settle ----
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && fields_in_flight == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
